### hw/rtl/tile_background_pixel_fetch_assert.svh
// assertion macros used by tbpf_fetch.sv
`ifndef TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH

// same-cycle implication
`define TBPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TBPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/tbpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbpf_pkg;

   localparam int VRAM_BYTES = 8192;
   localparam int BANK_DEPTH = VRAM_BYTES / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [1:0] CSR_SCROLL_X   = 2'd0;
   localparam logic [1:0] CSR_SCROLL_Y   = 2'd1;
   localparam logic [1:0] CSR_MAP_SELECT = 2'd2;

   // tile maps at 0x1800 and 0x1c00: top two address bits set
   localparam logic [1:0] MAP_TOP_BITS = 2'b11;

   typedef struct packed {
      logic        op;
      logic [12:0] write_address;
      logic [7:0]  write_data;
      logic [7:0]  pixel_column;
      logic [7:0]  pixel_line;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic [1:0]  color_index;
      logic [7:0]  out_column;
      logic [7:0]  out_line;
   } rsp_type;

   typedef struct packed {
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic       map_select;
   } cfg_type;

   function automatic logic [15:0] palette(input logic [1:0] idx);
      logic [15:0] color;
      case (idx)
         2'd0: color = 16'hFFFF;
         2'd1: color = 16'h6969;
         2'd2: color = 16'hA9A9;
         2'd3: color = 16'h0000;
         default: color = 16'h0000;
      endcase
      return color;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/tbpf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output      logic [WIDTH-1:0]         rdata_a,
   input  wire logic                     re_b,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output      logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read-before-write on a shared address
   always_ff @(posedge clock) begin
      if (re_a) begin
         rdata_a <= mem[raddr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (re_b) begin
         rdata_b <= mem[raddr_b];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/tbpf_fetch.sv
`timescale 1ns / 1ps
`default_nettype none
module tbpf_fetch (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tbpf_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire tbpf_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      tbpf_pkg::rsp_type rsp_data
);
   import tbpf_pkg::*;

   // stage 1: map byte in ram read register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_bank_ff;
   logic [2:0]          s1_sx_ff, s1_sy_ff;
   logic [7:0]          s1_col_ff, s1_line_ff;
   // stage 2: bitplane bytes in ram read registers
   logic                s2_valid_ff, s2_valid_in;
   logic [2:0]          s2_sx_ff;
   logic [7:0]          s2_col_ff, s2_line_ff;
   // output register
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;

   logic                out_free, s2_free, s1_move, s2_move;
   logic                accept, accept_render, accept_write;
   logic [7:0]          sx, sy;
   logic [BANK_AW-1:0]  map_index, row_index;
   logic [7:0]          even_map, odd_map, even_tile, odd_tile, map_byte;
   logic [1:0]          color_idx;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;

   assign accept        = req_valid && req_ready;
   assign accept_render = accept && (req_data.op == OP_RENDER);
   assign accept_write  = accept && (req_data.op == OP_WRITE);

   assign sx = 8'(req_data.pixel_column + cfg.scroll_x);
   assign sy = 8'(req_data.pixel_line + cfg.scroll_y);
   assign map_index = {MAP_TOP_BITS, cfg.map_select, sy[7:3], sx[7:4]};

   assign map_byte  = s1_bank_ff ? odd_map : even_map;
   assign row_index = {1'b0, map_byte, s1_sy_ff};

   // even bytes hold the low bitplane, odd bytes the high one
   tbpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
      .clock   (clock),
      .we      (accept_write && !req_data.write_address[0]),
      .waddr   (req_data.write_address[12:1]),
      .wdata   (req_data.write_data),
      .re_a    (accept_render),
      .raddr_a (map_index),
      .rdata_a (even_map),
      .re_b    (s1_move),
      .raddr_b (row_index),
      .rdata_b (even_tile)
   );

   tbpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
      .clock   (clock),
      .we      (accept_write && req_data.write_address[0]),
      .waddr   (req_data.write_address[12:1]),
      .wdata   (req_data.write_data),
      .re_a    (accept_render),
      .raddr_a (map_index),
      .rdata_a (odd_map),
      .re_b    (s1_move),
      .raddr_b (row_index),
      .rdata_b (odd_tile)
   );

   assign color_idx = {odd_tile[~s2_sx_ff], even_tile[~s2_sx_ff]};

   assign s1_valid_in  = accept ? accept_render : (s1_valid_ff && !s2_free);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !out_free);
   assign out_valid_in = s2_move || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_render) begin
         s1_bank_ff <= sx[3];
         s1_sx_ff   <= sx[2:0];
         s1_sy_ff   <= sy[2:0];
         s1_col_ff  <= req_data.pixel_column;
         s1_line_ff <= req_data.pixel_line;
      end
      if (s1_move) begin
         s2_sx_ff   <= s1_sx_ff;
         s2_col_ff  <= s1_col_ff;
         s2_line_ff <= s1_line_ff;
      end
      if (s2_move) begin
         out_data_ff.pixel_color <= palette(color_idx);
         out_data_ff.color_index <= color_idx;
         out_data_ff.out_column  <= s2_col_ff;
         out_data_ff.out_line    <= s2_line_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`include "tile_background_pixel_fetch_assert.svh"

   `TBPF_ASSERT_NEXT(a_render_enters, clock, reset, accept_render, s1_valid_ff)
   `TBPF_ASSERT_NEXT(a_write_no_slot, clock, reset, accept_write, !s1_valid_ff)
   `TBPF_ASSERT_NOW(a_full_stall, clock, reset,
      s1_valid_ff && s2_valid_ff && out_valid_ff && !rsp_ready, !req_ready)
   `TBPF_ASSERT_NEXT(a_s2_to_out, clock, reset, s2_move, out_valid_ff)
   `TBPF_ASSERT_NOW(a_idle_ready, clock, reset, !s1_valid_ff, req_ready)

endmodule
`default_nettype wire

### hw/rtl/tile_background_pixel_fetch.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                   payload
// req       in         req_valid / req_ready       req_data (tbpf_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready       rsp_data (tbpf_pkg::rsp_type)
// csr       in         csr_we, no wait             csr_index, csr_wdata
//
// one transfer per cycle on req while req_ready is high; a render pixel reaches rsp
// through the map byte read, the bitplane read and the output register
// video memory is two 4096 x 8 banks (even and odd bytes), each with two read ports
// reset clears the pipeline valids and the scroll and map registers, not memory
// an rsp stall holds the pipeline; req stays ready while any stage ahead can move
module tile_background_pixel_fetch (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire tbpf_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      tbpf_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);
   import tbpf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCROLL_X:   cfg_in.scroll_x   = csr_wdata;
            CSR_SCROLL_Y:   cfg_in.scroll_y   = csr_wdata;
            CSR_MAP_SELECT: cfg_in.map_select = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tbpf_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### test/tile_background_pixel_fetch_tb.sv
`timescale 1ns / 1ps
module tile_background_pixel_fetch_tb;
   import tbpf_pkg::*;

   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // shadow of the block: video memory, which bytes hold data, view registers
   logic [7:0] vram_q [VRAM_BYTES];
   bit vram_set [VRAM_BYTES];
   logic [7:0] scroll_x_q = '0;
   logic [7:0] scroll_y_q = '0;
   logic map_sel_q = 1'b0;

   rsp_type pixels_due [$];
   rsp_type want;
   int failures = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   tile_background_pixel_fetch dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** tile_background_pixel_fetch: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [12:0] map_entry_addr(input logic [7:0] col, input logic [7:0] line);
      logic [7:0] sx;
      logic [7:0] sy;
      sx = col + scroll_x_q;
      sy = line + scroll_y_q;
      return {MAP_TOP_BITS, map_sel_q, sy[7:3], sx[7:3]};
   endfunction

   function automatic logic [12:0] tile_row_addr(input logic [7:0] tile, input logic [7:0] line);
      logic [7:0] sy;
      sy = line + scroll_y_q;
      return {1'b0, tile, sy[2:0], 1'b0};
   endfunction

   function automatic rsp_type predict_pixel(input logic [7:0] col, input logic [7:0] line);
      rsp_type px;
      logic [7:0] sx;
      logic [12:0] row_a;
      logic [2:0] bit_pos;
      logic [1:0] idx;
      sx = col + scroll_x_q;
      row_a = tile_row_addr(vram_q[map_entry_addr(col, line)], line);
      bit_pos = 3'd7 - sx[2:0];
      // even byte is the low bit
      idx = {vram_q[row_a | 13'd1][bit_pos], vram_q[row_a][bit_pos]};
      case (idx)
         2'd0: px.pixel_color = 16'hFFFF;
         2'd1: px.pixel_color = 16'h6969;
         2'd2: px.pixel_color = 16'hA9A9;
         default: px.pixel_color = 16'h0000;
      endcase
      px.color_index = idx;
      px.out_column = col;
      px.out_line = line;
      return px;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixels_due.size() == 0) begin
            $error("pixel transfer with none pending: column %0d line %0d",
                   rsp_data.out_column, rsp_data.out_line);
            failures++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_data.pixel_color !== want.pixel_color) begin
               $error("pixel_color: expected %h, got %h", want.pixel_color, rsp_data.pixel_color);
               failures++;
            end
            if (rsp_data.color_index !== want.color_index) begin
               $error("color_index: expected %0d, got %0d", want.color_index,
                      rsp_data.color_index);
               failures++;
            end
            if (rsp_data.out_column !== want.out_column) begin
               $error("out_column: expected %0d, got %0d", want.out_column, rsp_data.out_column);
               failures++;
            end
            if (rsp_data.out_line !== want.out_line) begin
               $error("out_line: expected %0d, got %0d", want.out_line, rsp_data.out_line);
               failures++;
            end
         end
      end
   end

   // valid stays high after a transfer until the next call decides
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (item.op == OP_RENDER) begin
         pixels_due.insert(pixels_due.size(),
                           predict_pixel(item.pixel_column, item.pixel_line));
      end else begin
         vram_q[item.write_address] = item.write_data;
         vram_set[item.write_address] = 1'b1;
      end
   endtask

   task automatic poke(input logic [12:0] addr, input logic [7:0] data);
      req_type item;
      item.op = OP_WRITE;
      item.write_address = addr;
      item.write_data = data;
      item.pixel_column = 8'($urandom_range(255));
      item.pixel_line = 8'($urandom_range(255));
      send_item(item);
   endtask

   // fill any byte the pixel reads that holds no data yet, then render it
   task automatic render_pixel(input logic [7:0] col, input logic [7:0] line);
      req_type item;
      logic [12:0] map_a;
      logic [12:0] row_a;
      map_a = map_entry_addr(col, line);
      if (!vram_set[map_a]) poke(map_a, 8'($urandom_range(255)));
      row_a = tile_row_addr(vram_q[map_a], line);
      if (!vram_set[row_a]) poke(row_a, 8'($urandom_range(255)));
      if (!vram_set[row_a | 13'd1]) poke(row_a | 13'd1, 8'($urandom_range(255)));
      item.op = OP_RENDER;
      item.write_address = 13'($urandom_range(8191));
      item.write_data = 8'($urandom_range(255));
      item.pixel_column = col;
      item.pixel_line = line;
      send_item(item);
   endtask

   task automatic drain_pipe;
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] index, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_SCROLL_X: scroll_x_q = value;
         CSR_SCROLL_Y: scroll_y_q = value;
         CSR_MAP_SELECT: map_sel_q = value[0];
         default: ;
      endcase
   endtask

   task automatic set_view(input logic [7:0] sx, input logic [7:0] sy,
                           input logic [7:0] map_word, input logic [7:0] junk);
      csr_put(CSR_UNMAPPED, junk);
      csr_put(CSR_SCROLL_X, sx);
      csr_put(CSR_SCROLL_Y, sy);
      csr_put(CSR_MAP_SELECT, map_word);
      csr_we <= 1'b0;
   endtask

   task automatic test_tile_patterns;
      poke(13'h1800, 8'h00);
      poke(13'h0000, 8'h55);
      poke(13'h0001, 8'h33);
      render_pixel(8'd0, 8'd0);
      render_pixel(8'd1, 8'd0);
      render_pixel(8'd2, 8'd0);
      render_pixel(8'd3, 8'd0);
      render_pixel(8'd7, 8'd0);
      poke(13'h1BFF, 8'hFF);
      poke(13'h0FFE, 8'hFF);
      poke(13'h0FFF, 8'h00);
      render_pixel(8'd255, 8'd255);
      poke(13'h1FFF, 8'hFF);
      poke(13'h1C00, 8'h00);
      render_pixel(8'd159, 8'd143);
      render_pixel(8'd160, 8'd144);
      // map byte written then read right behind it
      poke(13'h1800, 8'hFF);
      render_pixel(8'd4, 8'd7);
   endtask

   task automatic test_view_registers;
      drain_pipe();
      set_view(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      render_pixel(8'd0, 8'd0);
      render_pixel(8'd1, 8'd1);
      render_pixel(8'd255, 8'd255);
      render_pixel(8'd159, 8'd143);
      drain_pipe();
      set_view(8'h80, 8'h01, 8'hFE, 8'h00);
      render_pixel(8'd0, 8'd0);
      render_pixel(8'd127, 8'd254);
      render_pixel(8'd128, 8'd255);
      drain_pipe();
      set_view(8'h00, 8'h00, 8'h00, 8'h5A);
      render_pixel(8'd0, 8'd0);
      render_pixel(8'd255, 8'd255);
   endtask

   task automatic run_phase(input int idle_pct, input int stall);
      int goal;
      int pick;
      bit paused;
      drain_pipe();
      set_view(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
      send_idle_pct = idle_pct;
      stall_pct = stall;
      goal = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            render_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
         end else if (pick < 85) begin
            poke(13'($urandom_range(8191)), 8'($urandom_range(255)));
         end else begin
            poke(13'($urandom_range(13'h1FFF, 13'h1800)), 8'($urandom_range(255)));
         end
         if (!paused && items_sent > goal - PHASE_ITEMS / 2) begin
            paused = 1'b1;
            drain_pipe();
         end
      end
   endtask

   task automatic test_random_scenes;
      run_phase(0, 0);
      run_phase(68, 0);
      run_phase(0, 68);
      run_phase(11, 11);
      run_phase(0, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tile_patterns();
      test_view_registers();
      test_random_scenes();
      drain_pipe();
      if (failures == 0) begin
         $display("** tile_background_pixel_fetch: PASSED **");
      end else begin
         $display("** tile_background_pixel_fetch: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tbpf_pkg.sv
hw/rtl/tbpf_ram.sv
hw/rtl/tbpf_fetch.sv
hw/rtl/tile_background_pixel_fetch.sv
test/tile_background_pixel_fetch_tb.sv
